[design/tof_pkg.sv]
// Shared types and constants for the two-way ranging time-of-flight block.
// No dependencies.
`default_nettype none
package tof_pkg;

  localparam int STAMP_BITS_DEF = 32;
  localparam logic [31:0] MPT_RESET = 32'd20144885;

  typedef struct packed {
    logic valid;
    logic neg;
    logic zero;
  } tof_ctl_t;

endpackage
`default_nettype wire

[design/tof_div_cell.sv]
// One restoring-division cell: produces one quotient bit per item per cycle.
// Depends on tof_pkg.
`default_nettype none
module tof_div_cell #(
  parameter int STAMP_BITS = tof_pkg::STAMP_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  tof_pkg::tof_ctl_t        ctl_in,
  input  wire  [STAMP_BITS+1:0]    den_in,
  input  wire  [STAMP_BITS+1:0]    rem_in,
  input  wire  [STAMP_BITS-1:0]    low_in,
  input  wire  [STAMP_BITS-1:0]    q_in,
  output tof_pkg::tof_ctl_t        ctl_out,
  output logic [STAMP_BITS+1:0]    den_out,
  output logic [STAMP_BITS+1:0]    rem_out,
  output logic [STAMP_BITS-1:0]    low_out,
  output logic [STAMP_BITS-1:0]    q_out
);
  import tof_pkg::*;

  localparam int S = STAMP_BITS;

  logic [S+2:0] trial;
  logic         ge;
  logic [S+2:0] diff;

  assign trial = {rem_in, low_in[S-1]};
  assign ge    = trial >= {1'b0, den_in};
  assign diff  = trial - {1'b0, den_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    den_out <= den_in;
    rem_out <= ge ? diff[S+1:0] : trial[S+1:0];
    low_out <= {low_in[S-2:0], 1'b0};
    q_out   <= {q_in[S-2:0], ge};
  end

endmodule
`default_nettype wire

[design/tof_front.sv]
// Front end: intervals, interval sum, split products and signed difference.
// Depends on tof_pkg.
`default_nettype none
module tof_front #(
  parameter int STAMP_BITS = tof_pkg::STAMP_BITS_DEF
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  input  wire  [31:0]               tag_poll_sent,
  input  wire  [31:0]               tag_resp_got,
  input  wire  [31:0]               tag_final_sent,
  input  wire  [31:0]               anchor_poll_got,
  input  wire  [31:0]               anchor_resp_sent,
  input  wire  [31:0]               anchor_final_got,
  output tof_pkg::tof_ctl_t         ctl_out,
  output logic [STAMP_BITS+1:0]     den_out,
  output logic [2*STAMP_BITS-1:0]   mag_out
);
  import tof_pkg::*;

  localparam int S  = STAMP_BITS;
  localparam int IW = (S < 32) ? S : 32;
  localparam int H  = (S + 1) / 2;
  localparam int G  = S - H;
  localparam int PW = 2 * S;

  logic [S-1:0] tp, tr, tf, ap, ar, af;
  assign tp = S'(tag_poll_sent[IW-1:0]);
  assign tr = S'(tag_resp_got[IW-1:0]);
  assign tf = S'(tag_final_sent[IW-1:0]);
  assign ap = S'(anchor_poll_got[IW-1:0]);
  assign ar = S'(anchor_resp_sent[IW-1:0]);
  assign af = S'(anchor_final_got[IW-1:0]);

  // stage 0: intervals
  logic         v0;
  logic [S-1:0] ra, da, db, rb;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= in_valid;
  end
  always_ff @(posedge clk) begin
    ra <= tr - tp;
    da <= tf - tr;
    db <= ar - ap;
    rb <= af - ar;
  end

  // stage 1: sum and partial products
  logic           v1, z1;
  logic [S+1:0]   den1;
  logic [2*H-1:0] a_ll, b_ll;
  logic [H+G-1:0] a_lh, a_hl, b_lh, b_hl;
  logic [2*G-1:0] a_hh, b_hh;
  logic [S+1:0]   den_sum;
  assign den_sum = (S+2)'(ra) + (S+2)'(rb) + (S+2)'(da) + (S+2)'(db);

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= v0;
  end
  always_ff @(posedge clk) begin
    z1   <= den_sum == '0;
    den1 <= den_sum;
    a_ll <= ra[H-1:0] * rb[H-1:0];
    a_lh <= ra[H-1:0] * rb[S-1:H];
    a_hl <= ra[S-1:H] * rb[H-1:0];
    a_hh <= ra[S-1:H] * rb[S-1:H];
    b_ll <= da[H-1:0] * db[H-1:0];
    b_lh <= da[H-1:0] * db[S-1:H];
    b_hl <= da[S-1:H] * db[H-1:0];
    b_hh <= da[S-1:H] * db[S-1:H];
  end

  // stage 2: assemble products
  logic          v2, z2;
  logic [S+1:0]  den2;
  logic [PW-1:0] p1, p2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end
  always_ff @(posedge clk) begin
    z2   <= z1;
    den2 <= den1;
    p1   <= (PW'(a_hh) << (2*H)) + PW'(a_ll) + ((PW'(a_lh) + PW'(a_hl)) << H);
    p2   <= (PW'(b_hh) << (2*H)) + PW'(b_ll) + ((PW'(b_lh) + PW'(b_hl)) << H);
  end

  // stage 3: signed difference as sign and magnitude
  logic neg3;
  assign neg3 = p1 < p2;
  always_ff @(posedge clk) begin
    if (rst) ctl_out.valid <= 1'b0;
    else     ctl_out.valid <= v2;
  end
  always_ff @(posedge clk) begin
    ctl_out.neg  <= neg3;
    ctl_out.zero <= z2;
    den_out      <= den2;
    mag_out      <= neg3 ? (p2 - p1) : (p1 - p2);
  end

endmodule
`default_nettype wire

[design/twr_time_of_flight_distance.sv]
// Top level: front end, chain of division cells, scaling and output register.
// Depends on tof_pkg, tof_front, tof_div_cell.
//
// Usage: drive the six timestamps with start high for one cycle; busy stays
// low, so a new item may be started in every cycle. Each item gives one
// result, shown for one cycle with done high: flight_ticks (signed ticks,
// truncated toward zero), distance_q16 (signed metres, 16 fraction bits) and
// zero_denominator (set when the interval sum is zero, results then zero).
// Between start and done an item passes the four front stages, one division
// cell per quotient bit, the scaling multiply and the output register.
// Throughput is one item per cycle. cfg_wr_en with cfg_wr_data writes the
// scale register mpt, metres per tick in Q0.32; write it only while no item
// is in flight. Reset clears all valid flags and loads the default scale.
// The receiver cannot stall: results are not held.
`default_nettype none
module twr_time_of_flight_distance #(
  parameter int STAMP_BITS = tof_pkg::STAMP_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [31:0] tag_poll_sent,
  input  wire  [31:0] tag_resp_got,
  input  wire  [31:0] tag_final_sent,
  input  wire  [31:0] anchor_poll_got,
  input  wire  [31:0] anchor_resp_sent,
  input  wire  [31:0] anchor_final_got,
  input  wire         cfg_wr_en,
  input  wire  [31:0] cfg_wr_data,
  output logic        done,
  output logic [32:0] flight_ticks,
  output logic [49:0] distance_q16,
  output logic        zero_denominator
);
  import tof_pkg::*;

  localparam int S  = STAMP_BITS;
  localparam int QW = (S > 33) ? S : 33;

  logic [31:0] mpt;
  always_ff @(posedge clk) begin
    if (rst)            mpt <= MPT_RESET;
    else if (cfg_wr_en) mpt <= cfg_wr_data;
  end

  assign busy = 1'b0;

  tof_ctl_t       ctl_c [0:S];
  logic [S+1:0]   den_c [0:S];
  logic [S+1:0]   rem_c [0:S];
  logic [S-1:0]   low_c [0:S];
  logic [S-1:0]   q_c   [0:S];
  logic [2*S-1:0] mag_f;

  tof_front #(.STAMP_BITS(S)) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (start & ~busy),
    .tag_poll_sent    (tag_poll_sent),
    .tag_resp_got     (tag_resp_got),
    .tag_final_sent   (tag_final_sent),
    .anchor_poll_got  (anchor_poll_got),
    .anchor_resp_sent (anchor_resp_sent),
    .anchor_final_got (anchor_final_got),
    .ctl_out          (ctl_c[0]),
    .den_out          (den_c[0]),
    .mag_out          (mag_f)
  );

  assign rem_c[0] = (S+2)'(mag_f[2*S-1:S]);
  assign low_c[0] = mag_f[S-1:0];
  assign q_c[0]   = '0;

  for (genvar i = 0; i < S; i++) begin : g_cell
    tof_div_cell #(.STAMP_BITS(S)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_c[i]),
      .den_in  (den_c[i]),
      .rem_in  (rem_c[i]),
      .low_in  (low_c[i]),
      .q_in    (q_c[i]),
      .ctl_out (ctl_c[i+1]),
      .den_out (den_c[i+1]),
      .rem_out (rem_c[i+1]),
      .low_out (low_c[i+1]),
      .q_out   (q_c[i+1])
    );
  end

  // saturate and scale
  logic [QW-1:0] q_w;
  logic [32:0]   mag_sat;
  logic          neg_a;
  assign q_w = QW'(q_c[S]);
  assign neg_a = ctl_c[S].neg & (q_c[S] != '0);
  always_comb begin
    if (neg_a && q_w > QW'(33'h1_0000_0000))       mag_sat = 33'h1_0000_0000;
    else if (!neg_a && q_w > QW'(33'h0_FFFF_FFFF)) mag_sat = 33'h0_FFFF_FFFF;
    else                                           mag_sat = q_w[32:0];
  end

  logic        va, za, nb;
  logic [32:0] mag_b;
  logic [64:0] dmag;
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= ctl_c[S].valid;
  end
  always_ff @(posedge clk) begin
    za    <= ctl_c[S].zero;
    nb    <= neg_a;
    mag_b <= mag_sat;
    dmag  <= 65'(mag_sat) * 65'(mpt);
  end

  logic [64:0] dist_full;
  logic [32:0] flight_full;
  assign dist_full   = nb ? (65'd0 - ((dmag + 65'hFFFF) >> 16)) : (dmag >> 16);
  assign flight_full = nb ? (33'd0 - mag_b) : mag_b;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= va;
  end
  always_ff @(posedge clk) begin
    zero_denominator <= za;
    flight_ticks     <= za ? '0 : flight_full;
    distance_q16     <= za ? '0 : dist_full[49:0];
  end

`ifndef NO_ASSERTIONS
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    va |=> done)
    else $error("result strobe lost");
  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    (done && zero_denominator) |-> (flight_ticks == '0 && distance_q16 == '0))
    else $error("zero denominator with nonzero result");
  a_zero_flight: assert property (@(posedge clk) disable iff (rst)
    (done && flight_ticks == '0) |-> (distance_q16 == '0))
    else $error("distance nonzero for zero flight time");
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("strobe after reset");
`endif

endmodule
`default_nettype wire
